[sv/kpd_pkg.sv]
// Shared types, constants and decode helpers for the keypad debounce block.
package kpd_pkg;

  typedef enum logic [1:0] {
    PHASE_UP      = 2'd0,
    PHASE_FALLING = 2'd1,
    PHASE_DOWN    = 2'd2,
    PHASE_RISING  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    CLASS_NONE  = 2'd0,
    CLASS_SHORT = 2'd1,
    CLASS_LONG  = 2'd2
  } press_class_t;

  typedef enum logic {
    KIND_SCAN = 1'b0,
    KIND_READ = 1'b1
  } kind_t;

  typedef enum logic {
    REG_DEBOUNCE_TICKS   = 1'b0,
    REG_LONG_PRESS_TICKS = 1'b1
  } reg_index_t;

  localparam logic [7:0] HOLD_LIMIT          = 8'd200;
  localparam logic [7:0] IDLE_LIMIT          = 8'd4;
  localparam logic [7:0] DEBOUNCE_TICKS_RST  = 8'd3;
  localparam logic [7:0] LONG_PRESS_TICKS_RST = 8'd100;
  localparam logic [4:0] KEY_NONE            = 5'd0;

  // Maps a one-hot nibble to its bit position in the low two bits; the top bit is low for any other pattern.
  function automatic logic [2:0] one_hot_index(input logic [3:0] v);
    logic [2:0] r;
    case (v)
      4'b0001: r = 3'b100;
      4'b0010: r = 3'b101;
      4'b0100: r = 3'b110;
      4'b1000: r = 3'b111;
      default: r = 3'b000;
    endcase
    return r;
  endfunction

  // Key number 1..16 from column and row samples, zero when either is not one-hot.
  function automatic logic [4:0] decode_key(input logic [3:0] col, input logic [3:0] row);
    logic [2:0] c;
    logic [2:0] r;
    c = one_hot_index(col);
    r = one_hot_index(row);
    if (c[2] && r[2]) begin
      return {1'b0, r[1:0], c[1:0]} + 5'd1;
    end
    return KEY_NONE;
  endfunction

endpackage

[sv/kpd_if.sv]
// Handshake interfaces for the keypad debounce block: scan input, status output, configuration.
interface kpd_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [3:0] column_sense;
  logic [3:0] row_sense;
  modport source (output valid, output kind, output column_sense, output row_sense,
                  input ready);
  modport sink (input valid, input kind, input column_sense, input row_sense,
                output ready);
endinterface

interface kpd_out_if;
  logic       valid;
  logic       ready;
  logic [4:0] key_code;
  logic       key_ready;
  logic [1:0] press_class;
  modport source (output valid, output key_code, output key_ready, output press_class,
                  input ready);
  modport sink (input valid, input key_code, input key_ready, input press_class,
                output ready);
endinterface

interface kpd_cfg_if;
  logic       valid;
  logic       ready;
  logic       index;
  logic [7:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[sv/keypad_debounce_press_classifier.sv]
// Top level of the 4x4 keypad scanner with debounce and short/long press classification.
//
//   channel | modport | word carries
//   --------+---------+------------------------------------------------
//   cfg     | sink    | index (0 debounce_ticks, 1 long_press_ticks), data
//   src     | sink    | kind, column_sense, row_sense
//   res     | source  | key_code, key_ready, press_class
//
// Every input word is handled in the cycle it is accepted: the debounce state
// is updated at that edge and the status word lands in the result register,
// so one word per cycle is sustained while the consumer takes the results.
// The only thing that holds the input back is a full result register that the
// consumer has not taken; a new word is accepted in the same cycle the old one
// leaves. Synchronous reset returns the machine to the up phase, clears all
// counters and flags, and loads the register defaults. Configuration writes
// are always taken.
module keypad_debounce_press_classifier (
  input logic clk,
  input logic rst,
  kpd_cfg_if.sink cfg,
  kpd_in_if.sink src,
  kpd_out_if.source res
);
  import kpd_pkg::*;

  // Configuration registers.
  logic [7:0] debounce_ticks;
  logic [7:0] long_press_ticks;

  // Debounce and classification state.
  phase_t       phase;
  phase_t       phase_next;
  logic [8:0]   debounce_count;
  logic [8:0]   debounce_count_next;
  logic [7:0]   hold_count;
  logic [7:0]   hold_count_next;
  logic [4:0]   latched_key;
  logic [4:0]   latched_key_next;
  logic         ready_flag;
  logic         ready_flag_next;
  press_class_t press_state;
  press_class_t press_state_next;

  // Result register.
  logic         out_valid;
  logic [4:0]   out_key;
  logic         out_ready_flag;
  press_class_t out_class;

  logic [4:0] key;
  logic [7:0] hold_inc;
  logic [8:0] debounce_step;
  logic       settled;
  logic       accept;
  logic       scan;
  logic       read;

  assign cfg.ready = 1'b1;

  // The result register frees up either when empty or when its word is taken now.
  assign src.ready = !out_valid || res.ready;
  assign accept    = src.valid && src.ready;
  assign scan      = accept && (src.kind == KIND_SCAN);
  assign read      = accept && (src.kind == KIND_READ);

  assign key      = decode_key(src.column_sense, src.row_sense);
  assign hold_inc = hold_count + 8'd1;

  // Stable-tick count after this tick: a press counts up in the up phase and a
  // release counts up in the down phase; anything else starts over.
  assign debounce_step = ((phase == PHASE_UP && key != KEY_NONE) ||
                          (phase == PHASE_DOWN && key == KEY_NONE)) ?
                         debounce_count + 9'd1 : 9'd0;

  // A press in the up phase or a release in the down phase is accepted once
  // the updated stable-tick count passes the debounce setting.
  assign settled = (debounce_step > {1'b0, debounce_ticks});

  // Next phase of the debounce machine.
  always_comb begin
    phase_next = phase;
    case (phase)
      PHASE_UP: begin
        if (settled) begin
          phase_next = PHASE_FALLING;
        end
      end
      PHASE_FALLING: begin
        phase_next = PHASE_DOWN;
      end
      PHASE_DOWN: begin
        if (settled) begin
          phase_next = PHASE_RISING;
        end
      end
      PHASE_RISING: begin
        phase_next = PHASE_UP;
      end
      default: begin
        phase_next = PHASE_UP;
      end
    endcase
  end

  // Counters, latched key, ready flag and press class for one scan tick.
  always_comb begin
    debounce_count_next = debounce_count;
    hold_count_next     = hold_count;
    latched_key_next    = latched_key;
    ready_flag_next     = ready_flag;
    press_state_next    = press_state;
    case (phase)
      PHASE_UP: begin
        if (key != KEY_NONE) begin
          debounce_count_next = debounce_count + 9'd1;
        end else begin
          // Idle ticks count up in the hold counter; after five of them the
          // latched key is dropped.
          debounce_count_next = '0;
          if (hold_inc > IDLE_LIMIT) begin
            latched_key_next = KEY_NONE;
            hold_count_next  = '0;
          end else begin
            hold_count_next = hold_inc;
          end
        end
        if (settled) begin
          debounce_count_next = '0;
          press_state_next    = CLASS_NONE;
          latched_key_next    = key;
        end
      end
      PHASE_FALLING: begin
        ready_flag_next = 1'b1;
      end
      PHASE_DOWN: begin
        if (key == KEY_NONE) begin
          debounce_count_next = debounce_count + 9'd1;
        end else begin
          // Any key still down keeps the hold going, saturating at the limit.
          debounce_count_next = '0;
          if (hold_count < HOLD_LIMIT) begin
            hold_count_next = hold_inc;
          end
          if (hold_count_next >= long_press_ticks) begin
            press_state_next = CLASS_LONG;
          end
        end
        if (settled) begin
          debounce_count_next = '0;
          press_state_next    = CLASS_NONE;
        end
      end
      default: begin
        // Rising edge of the release: a hold under half the long setting is short.
        if (hold_count < {1'b0, long_press_ticks[7:1]}) begin
          press_state_next = CLASS_SHORT;
        end
        hold_count_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks   <= DEBOUNCE_TICKS_RST;
      long_press_ticks <= LONG_PRESS_TICKS_RST;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_DEBOUNCE_TICKS:   debounce_ticks   <= cfg.data;
        REG_LONG_PRESS_TICKS: long_press_ticks <= cfg.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PHASE_UP;
      debounce_count <= '0;
      hold_count     <= '0;
      latched_key    <= KEY_NONE;
      ready_flag     <= 1'b0;
      press_state    <= CLASS_NONE;
    end else if (scan) begin
      phase          <= phase_next;
      debounce_count <= debounce_count_next;
      hold_count     <= hold_count_next;
      latched_key    <= latched_key_next;
      ready_flag     <= ready_flag_next;
      press_state    <= press_state_next;
    end else if (read) begin
      ready_flag <= 1'b0;
    end
  end

  // A read reports the status as it stands before the ready flag is cleared;
  // a scan tick reports the status after its update.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (read) begin
      out_key        <= latched_key;
      out_ready_flag <= ready_flag;
      out_class      <= press_state;
    end else if (scan) begin
      out_key        <= latched_key_next;
      out_ready_flag <= ready_flag_next;
      out_class      <= press_state_next;
    end
  end

  assign res.valid       = out_valid;
  assign res.key_code    = out_key;
  assign res.key_ready   = out_ready_flag;
  assign res.press_class = out_class;

endmodule

[sv/kpd_checker.sv]
// Port-level checker for the keypad debounce block and its bind to the top level.
module kpd_port_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [4:0] key_code,
  input logic [1:0] press_class
);
  import kpd_pkg::*;

  // A waiting result word stays put until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(key_code) && $stable(press_class))
    else $error("result word changed or dropped while stalled");

  // Every accepted input word yields a result word in the next cycle.
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted word produced no result");

  // Input is held back only while an untaken result is pending.
  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  // Reported key numbers and classes stay in their legal ranges.
  a_ranges: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (key_code <= 5'd16) && (press_class != 2'd3))
    else $error("result field out of range");

endmodule

bind keypad_debounce_press_classifier kpd_port_checker u_kpd_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (src.valid),
  .in_ready    (src.ready),
  .out_valid   (res.valid),
  .out_ready   (res.ready),
  .key_code    (res.key_code),
  .press_class (res.press_class)
);

[tb/kpd_checker.sv]
// Checker for the keypad debouncer: tracks its state, predicts each status word and compares.
module kpd_checker (
  input  logic clk,
  input  logic rst,
  kpd_cfg_if   cfg,
  kpd_in_if    src,
  kpd_out_if   res,
  output int   failures,
  output int   pending_words,
  output int   short_words,
  output int   long_words
);
  import kpd_pkg::*;

  typedef struct packed {
    logic [4:0]   code;
    logic         flag;
    press_class_t cls;
  } status_word_t;

  status_word_t expected_status[$];

  logic [7:0]   cfg_debounce;
  logic [7:0]   cfg_long;
  phase_t       phase;
  logic [8:0]   bounce_cnt;
  logic [7:0]   hold_cnt;
  logic [4:0]   key_latched;
  logic         ready_flag;
  press_class_t press_cls;

  // Key 1..16 when both nibbles are one-hot, otherwise no key.
  function automatic logic [4:0] key_from_sense(input logic [3:0] col, input logic [3:0] row);
    logic [4:0] code;
    code = KEY_NONE;
    if ($onehot(col) && $onehot(row)) begin
      for (int c = 0; c < 4; c++) begin
        for (int r = 0; r < 4; r++) begin
          if (col[c] && row[r]) begin
            code = 5'(c + 4 * r + 1);
          end
        end
      end
    end
    return code;
  endfunction

  task predict_status(input kind_t kind_v, input logic [3:0] col, input logic [3:0] row);
    logic [4:0] key;
    key = key_from_sense(col, row);
    if (kind_v == KIND_READ) begin
      // A read reports the status first and drops the ready flag afterwards.
      expected_status.push_back('{code: key_latched, flag: ready_flag, cls: press_cls});
      ready_flag = 1'b0;
      return;
    end
    case (phase)
      PHASE_UP: begin
        if (key != KEY_NONE) begin
          bounce_cnt = bounce_cnt + 9'd1;
        end else begin
          bounce_cnt = '0;
          hold_cnt = hold_cnt + 8'd1;
          if (hold_cnt > IDLE_LIMIT) begin
            key_latched = KEY_NONE;
            hold_cnt = '0;
          end
        end
        if (bounce_cnt > {1'b0, cfg_debounce}) begin
          bounce_cnt = '0;
          phase = PHASE_FALLING;
          press_cls = CLASS_NONE;
          key_latched = key;
        end
      end
      PHASE_FALLING: begin
        phase = PHASE_DOWN;
        ready_flag = 1'b1;
      end
      PHASE_DOWN: begin
        if (key == KEY_NONE) begin
          bounce_cnt = bounce_cnt + 9'd1;
        end else begin
          bounce_cnt = '0;
          if (hold_cnt < HOLD_LIMIT) begin
            hold_cnt = hold_cnt + 8'd1;
          end
          if (hold_cnt >= cfg_long) begin
            press_cls = CLASS_LONG;
          end
        end
        if (bounce_cnt > {1'b0, cfg_debounce}) begin
          bounce_cnt = '0;
          phase = PHASE_RISING;
          press_cls = CLASS_NONE;
        end
      end
      default: begin
        phase = PHASE_UP;
        if (hold_cnt < (cfg_long >> 1)) begin
          press_cls = CLASS_SHORT;
        end
        hold_cnt = '0;
      end
    endcase
    expected_status.push_back('{code: key_latched, flag: ready_flag, cls: press_cls});
  endtask

  initial begin
    failures = 0;
    short_words = 0;
    long_words = 0;
  end

  always @(posedge clk) begin
    status_word_t want;
    if (rst) begin
      cfg_debounce = DEBOUNCE_TICKS_RST;
      cfg_long = LONG_PRESS_TICKS_RST;
      phase = PHASE_UP;
      bounce_cnt = '0;
      hold_cnt = '0;
      key_latched = KEY_NONE;
      ready_flag = 1'b0;
      press_cls = CLASS_NONE;
      expected_status.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == REG_DEBOUNCE_TICKS) begin
          cfg_debounce = cfg.data;
        end else begin
          cfg_long = cfg.data;
        end
      end
      // Results leave before the word accepted at this edge is predicted.
      if (res.valid && res.ready) begin
        if (expected_status.size() == 0) begin
          $error("status word arrived with nothing expected: key_code %0d", res.key_code);
          failures++;
        end else begin
          want = expected_status.pop_front();
          if (res.key_code !== want.code) begin
            $error("key_code: expected %0d, got %0d", want.code, res.key_code);
            failures++;
          end
          if (res.key_ready !== want.flag) begin
            $error("key_ready: expected %0d, got %0d", want.flag, res.key_ready);
            failures++;
          end
          if (res.press_class !== want.cls) begin
            $error("press_class: expected %0d, got %0d", want.cls, res.press_class);
            failures++;
          end
          if (want.cls == CLASS_SHORT) short_words++;
          if (want.cls == CLASS_LONG) long_words++;
        end
      end
      if (src.valid && src.ready) begin
        predict_status(kind_t'(src.kind), src.column_sense, src.row_sense);
      end
    end
    pending_words <= expected_status.size();
  end

endmodule

[tb/tb_top.sv]
// Top of the keypad debouncer testbench: clock, reset, stimulus, idling and the verdict.
module tb_top;
  import kpd_pkg::*;

  localparam int CYCLE_LIMIT     = 400000;
  localparam int HOLD_OFF_CYCLES = 300;

  logic clk = 1'b0;
  logic rst;

  kpd_cfg_if cfg_ch();
  kpd_in_if  src_ch();
  kpd_out_if res_ch();

  int fail_count;
  int pending;
  int short_seen;
  int long_seen;

  // Counters for the stimulus and the run summary.
  int cycle_count = 0;
  int words_offered = 0;
  int reads_offered = 0;
  int reg_writes = 0;
  int settings_used = 0;

  // Idling percentages, picked per stretch of words by the sender and read by the receiver.
  int src_idle_pct = 0;
  int sink_stall_pct = 0;

  // The receiver serves one long hold-off each time the request count moves on.
  int hold_off_requests = 0;
  int hold_offs_served = 0;

  // Mirror of the register values, used to size presses and releases.
  int cur_debounce = DEBOUNCE_TICKS_RST;
  int cur_long = LONG_PRESS_TICKS_RST;

  // While set, scan words are now and then preceded by a status read.
  bit sprinkle_reads = 1'b0;

  keypad_debounce_press_classifier uut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .src (src_ch),
    .res (res_ch)
  );

  kpd_checker chk (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg_ch),
    .src           (src_ch),
    .res           (res_ch),
    .failures      (fail_count),
    .pending_words (pending),
    .short_words   (short_seen),
    .long_words    (long_seen)
  );

  always #5 clk = ~clk;

  // Watchdog: a hung handshake or a lost status word ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Receiver. Normally ready follows the current stall percentage. When a hold-off is
  // requested it keeps ready low for a long stretch so that the result register fills
  // and the block has to push back on its input.
  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_offs_served != hold_off_requests) begin
        hold_offs_served = hold_off_requests;
        res_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(posedge clk);
      end else begin
        res_ch.ready <= (sink_stall_pct == 0) || ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // Offers one word and returns at the edge where it is taken. The idling mode moves on
  // every 40 words: none, sender gaps, receiver stalls, then light gaps on both sides.
  task automatic send_word(input kind_t kind_v, input logic [3:0] col, input logic [3:0] row);
    int mode;
    mode = (words_offered / 40) % 4;
    case (mode)
      0: begin
        src_idle_pct = 0;
        sink_stall_pct = 0;
      end
      1: begin
        src_idle_pct = 50;
        sink_stall_pct = 0;
      end
      2: begin
        src_idle_pct = 0;
        sink_stall_pct = 50;
      end
      default: begin
        src_idle_pct = 9;
        sink_stall_pct = 9;
      end
    endcase
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      src_ch.valid <= 1'b0;
      @(posedge clk);
    end
    src_ch.valid <= 1'b1;
    src_ch.kind <= kind_v;
    src_ch.column_sense <= col;
    src_ch.row_sense <= row;
    do @(posedge clk); while (!src_ch.ready);
    words_offered++;
    if (kind_v == KIND_READ) reads_offered++;
  endtask

  // A scan tick, sometimes preceded by a status read with junk in the sample fields.
  task automatic send_scan(input logic [3:0] col, input logic [3:0] row);
    if (sprinkle_reads && $urandom_range(7) == 0) begin
      send_word(KIND_READ, 4'($urandom), 4'($urandom));
    end
    send_word(KIND_SCAN, col, row);
  endtask

  // Stops offering, waits for every expected status word, then lets the pipeline settle.
  // pending is registered in the checker and lags its queue, so the loop always looks after an edge.
  task automatic drain();
    src_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [7:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
    reg_writes++;
    if (idx == REG_DEBOUNCE_TICKS) cur_debounce = value;
    else cur_long = value;
  endtask

  // One press of a random key: some contact bounce, a hold with the odd foreign key or
  // dropout, then a release long enough to be accepted and a few idle ticks.
  task automatic press_and_release(input int hold_len);
    int key;
    logic [3:0] col;
    logic [3:0] row;
    key = $urandom_range(15);
    col = 4'b0001 << (key % 4);
    row = 4'b0001 << (key / 4);
    repeat ($urandom_range(3)) send_scan($urandom_range(1) ? col : 4'h0, row);
    for (int i = 0; i < hold_len; i++) begin
      if ($urandom_range(19) == 0) begin
        send_scan(4'b0001 << $urandom_range(3), 4'b0001 << $urandom_range(3));
      end else if ($urandom_range(29) == 0) begin
        send_scan(4'h0, row);
      end else begin
        send_scan(col, row);
      end
    end
    // Column zero always decodes to no key, so the row lines may carry anything.
    repeat (cur_debounce + 1 + $urandom_range(3)) send_scan(4'h0, 4'($urandom));
    repeat ($urandom_range(8)) send_scan(4'h0, 4'h0);
  endtask

  // Random traffic for the current register setting: mostly whole presses with short,
  // long and saturating holds, the rest raw noise and presses cut off during bounce.
  task automatic random_traffic(input int n_words);
    int stop_at;
    int pick;
    int len;
    stop_at = words_offered + n_words;
    sprinkle_reads = 1'b1;
    while (words_offered < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        pick = $urandom_range(9);
        if (pick < 6) len = cur_debounce + 2 + $urandom_range(cur_long / 2);
        else if (pick < 9) len = cur_debounce + 2 + cur_long + $urandom_range(10);
        else len = cur_debounce + 2 + 200 + $urandom_range(10);
        press_and_release(len);
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 6)) begin
          send_word(kind_t'($urandom_range(1)), 4'($urandom), 4'($urandom));
        end
      end else begin
        repeat ($urandom_range(cur_debounce)) send_scan(4'b0100, 4'b0010);
        send_scan(4'h0, 4'h0);
      end
    end
    sprinkle_reads = 1'b0;
  endtask

  initial begin
    rst <= 1'b1;
    src_ch.valid <= 1'b0;
    src_ch.kind <= KIND_SCAN;
    src_ch.column_sense <= 4'h0;
    src_ch.row_sense <= 4'h0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= REG_DEBOUNCE_TICKS;
    cfg_ch.data <= 8'h00;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part on the reset settings (debounce 3, long press 100).
    settings_used++;
    send_word(KIND_READ, 4'h0, 4'h0);
    // Samples that are not one-hot: empty column, full column, empty row, two columns.
    send_scan(4'h0, 4'h1);
    send_scan(4'hF, 4'h8);
    send_scan(4'h1, 4'h0);
    send_scan(4'h3, 4'h1);
    // Key 16 held: accepted on the fourth stable tick, ready raised one tick later.
    repeat (6) send_scan(4'h8, 4'h8);
    // Another key while down still counts as pressed.
    repeat (2) send_scan(4'h1, 4'h1);
    // The first read still shows ready, the second one sees it cleared.
    send_word(KIND_READ, 4'hF, 4'hF);
    send_word(KIND_READ, 4'h0, 4'h0);
    // Quick release ends as a short press; five idle ticks then clear the latched key.
    repeat (5) send_scan(4'h0, 4'h0);
    repeat (5) send_scan(4'h0, 4'h0);
    send_word(KIND_READ, 4'h0, 4'h0);
    random_traffic(40);
    drain();

    // Fastest settings, with a long receiver hold-off to back up the input.
    write_reg(REG_DEBOUNCE_TICKS, 8'd0);
    write_reg(REG_LONG_PRESS_TICKS, 8'd1);
    settings_used++;
    hold_off_requests++;
    random_traffic(30);
    drain();

    // A long-press threshold of zero makes every held tick a long press.
    write_reg(REG_DEBOUNCE_TICKS, 8'd1);
    write_reg(REG_LONG_PRESS_TICKS, 8'd0);
    settings_used++;
    random_traffic(20);
    drain();

    // Threshold at the hold ceiling: only a saturated hold counts as long.
    write_reg(REG_DEBOUNCE_TICKS, 8'd2);
    write_reg(REG_LONG_PRESS_TICKS, 8'd200);
    settings_used++;
    random_traffic(60);
    drain();

    // Largest debounce and a threshold the hold count can never reach: one press that
    // needs the full stable-tick count to be accepted, released later under a short
    // debounce.
    write_reg(REG_DEBOUNCE_TICKS, 8'd255);
    write_reg(REG_LONG_PRESS_TICKS, 8'd255);
    settings_used++;
    sprinkle_reads = 1'b1;
    repeat (262) send_scan(4'h1, 4'h8);
    sprinkle_reads = 1'b0;
    drain();
    write_reg(REG_DEBOUNCE_TICKS, 8'd1);
    settings_used++;
    repeat (4) send_scan(4'h0, 4'h0);
    send_word(KIND_READ, 4'h0, 4'h0);
    drain();

    // A middling setting to finish.
    write_reg(REG_DEBOUNCE_TICKS, 8'd4);
    write_reg(REG_LONG_PRESS_TICKS, 8'd9);
    settings_used++;
    random_traffic(20);
    drain();

    $display("summary: %0d words (%0d status reads), %0d register writes over %0d settings",
             words_offered, reads_offered, reg_writes, settings_used);
    $display("summary: %0d status words reported short presses, %0d long presses",
             short_seen, long_seen);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
